// ===== hdl/arc_pkg.sv =====
package arc_pkg;

   localparam int unsigned CharWidth = 8;
   localparam int unsigned MaxEmit   = 3;
   localparam int unsigned CountWidth = $clog2(MaxEmit + 1);

   localparam logic [CharWidth-1:0] DashCode    = 8'd45;
   localparam logic [CharWidth-1:0] DigitLow    = 8'd48;
   localparam logic [CharWidth-1:0] DigitEnd    = 8'd58;
   localparam logic [CharWidth-1:0] UpperLow    = 8'd65;
   localparam logic [CharWidth-1:0] UpperEnd    = 8'd91;
   localparam logic [CharWidth-1:0] LowerLow    = 8'd97;
   localparam logic [CharWidth-1:0] LowerEnd    = 8'd123;
   localparam logic [CharWidth-1:0] MaxCode     = 8'hFF;

   // run length classes
   localparam logic [1:0] ClassOne  = 2'd1;
   localparam logic [1:0] ClassTwo  = 2'd2;
   localparam logic [1:0] ClassMore = 2'd3;

   typedef logic [CharWidth-1:0] char_type;
   typedef logic [CountWidth-1:0] count_type;

   // contracted form of a closed run, handed from tracker to emitter
   typedef struct packed {
      count_type count;
      char_type  char0;
      char_type  char1;
      char_type  char2;
   } flush_type;

   function automatic logic is_alnum(input char_type c);
      return (c >= DigitLow && c < DigitEnd) || (c >= UpperLow && c < UpperEnd) ||
             (c >= LowerLow && c < LowerEnd);
   endfunction

endpackage

// ===== hdl/arc_req_if.sv =====
interface arc_req_if;
   logic                valid;
   logic                ready;
   arc_pkg::char_type   in_char;
   logic                end_of_string;

   modport source (output valid, output in_char, output end_of_string, input ready);
   modport sink   (input valid, input in_char, input end_of_string, output ready);
endinterface

// ===== hdl/arc_rsp_if.sv =====
interface arc_rsp_if;
   logic                valid;
   logic                ready;
   arc_pkg::char_type   out_char;
   logic                last_of_run;

   modport source (output valid, output out_char, output last_of_run, input ready);
   modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

// ===== hdl/arc_tracker.sv =====
module arc_tracker (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  arc_pkg::char_type   in_char,
   input  logic                end_of_string,
   output arc_pkg::flush_type  flush
);

   arc_pkg::char_type run_start_ff, run_start_in;
   arc_pkg::char_type prev_char_ff, prev_char_in;
   logic [1:0]        run_class_ff, run_class_in;
   logic              have_char_ff, have_char_in;

   logic extend;
   logic close_run;

   assign extend = have_char_ff && arc_pkg::is_alnum(prev_char_ff) &&
                   (prev_char_ff != arc_pkg::MaxCode) &&
                   (prev_char_ff + arc_pkg::char_type'(1) == in_char);

   assign close_run = take && have_char_ff && (end_of_string || !extend);

   always_comb begin
      flush.char0 = run_start_ff;
      flush.char1 = prev_char_ff;
      flush.char2 = prev_char_ff;
      case (run_class_ff)
         arc_pkg::ClassTwo: begin
            flush.count = arc_pkg::count_type'(2);
         end
         arc_pkg::ClassMore: begin
            flush.count = arc_pkg::count_type'(3);
            flush.char1 = arc_pkg::DashCode;
         end
         default: begin
            flush.count = arc_pkg::count_type'(1);
         end
      endcase
      if (!close_run) begin
         flush.count = '0;
      end
   end

   always_comb begin
      run_start_in = run_start_ff;
      prev_char_in = prev_char_ff;
      run_class_in = run_class_ff;
      have_char_in = have_char_ff;
      if (take) begin
         if (end_of_string) begin
            run_start_in = '0;
            prev_char_in = '0;
            run_class_in = arc_pkg::ClassOne;
            have_char_in = 1'b0;
         end else if (extend) begin
            prev_char_in = in_char;
            if (run_class_ff != arc_pkg::ClassMore) begin
               run_class_in = (run_class_ff == arc_pkg::ClassTwo) ? arc_pkg::ClassMore
                                                                  : arc_pkg::ClassTwo;
            end
         end else begin
            // open a new run with this byte
            run_start_in = in_char;
            prev_char_in = in_char;
            run_class_in = arc_pkg::ClassOne;
            have_char_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_start_ff <= '0;
         prev_char_ff <= '0;
         run_class_ff <= arc_pkg::ClassOne;
         have_char_ff <= 1'b0;
      end else begin
         run_start_ff <= run_start_in;
         prev_char_ff <= prev_char_in;
         run_class_ff <= run_class_in;
         have_char_ff <= have_char_in;
      end
   end

endmodule

// ===== hdl/arc_emitter.sv =====
module arc_emitter (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  arc_pkg::flush_type  flush,
   input  logic                out_ready,
   output logic                out_valid,
   output arc_pkg::char_type   out_char,
   output logic                out_last,
   output logic                can_load,
   output arc_pkg::count_type  pending
);

   arc_pkg::count_type count_ff, count_in;
   arc_pkg::char_type  slot_ff [arc_pkg::MaxEmit];
   arc_pkg::char_type  slot_in [arc_pkg::MaxEmit];

   logic transfer;

   assign out_valid = (count_ff != '0);
   assign out_char  = slot_ff[0];
   assign out_last  = (count_ff == arc_pkg::count_type'(1));
   assign transfer  = out_valid && out_ready;
   // room once the last pending byte leaves in this cycle
   assign can_load  = (count_ff == '0) || (out_last && out_ready);
   assign pending   = count_ff;

   always_comb begin
      count_in = count_ff;
      for (int i = 0; i < arc_pkg::MaxEmit; i++) begin
         slot_in[i] = slot_ff[i];
      end
      if (load) begin
         count_in   = flush.count;
         slot_in[0] = flush.char0;
         slot_in[1] = flush.char1;
         slot_in[2] = flush.char2;
      end else if (transfer) begin
         // advance the queue by one byte
         count_in = count_ff - arc_pkg::count_type'(1);
         for (int i = 0; i < arc_pkg::MaxEmit - 1; i++) begin
            slot_in[i] = slot_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      for (int i = 0; i < arc_pkg::MaxEmit; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

endmodule

// ===== hdl/ascending_run_contractor.sv =====
// A byte that closes a run shows its first result in the cycle after its transfer.
// Throughput: one item per cycle while the result queue is empty or its last byte goes;
// an item that closes a run queues one to three bytes, sent one per cycle while ready.
// Reset: synchronous, active high; clears the run state and empties the result queue.
module ascending_run_contractor (
   input  logic       clock,
   input  logic       reset,
   arc_req_if.sink    req_chan,
   arc_rsp_if.source  rsp_chan
);

   arc_pkg::flush_type flush;
   arc_pkg::count_type pending;
   logic               can_load;
   logic               take;

   assign req_chan.ready = can_load;
   assign take = req_chan.valid && can_load;

   arc_tracker u_tracker (
      .clock         (clock),
      .reset         (reset),
      .take          (take),
      .in_char       (req_chan.in_char),
      .end_of_string (req_chan.end_of_string),
      .flush         (flush)
   );

   arc_emitter u_emitter (
      .clock     (clock),
      .reset     (reset),
      .load      (take),
      .flush     (flush),
      .out_ready (rsp_chan.ready),
      .out_valid (rsp_chan.valid),
      .out_char  (rsp_chan.out_char),
      .out_last  (rsp_chan.last_of_run),
      .can_load  (can_load),
      .pending   (pending)
   );

`ifndef SYNTHESIS
   // a new item never lands on a queue still holding more than one byte
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      take |-> (pending == arc_pkg::count_type'(0) || pending == arc_pkg::count_type'(1)))
      else $error("item taken while result queue busy");

   // a run's contraction continues without gaps until its last byte
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && !rsp_chan.last_of_run) |=> rsp_chan.valid)
      else $error("result queue drained before last byte");

   // queue empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result valid after reset");
`endif

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;

   localparam int unsigned RandomItems = 400;
   localparam int unsigned HoldCycles  = 300;
   localparam int unsigned DrainLimit  = 5000;
   localparam int unsigned EndSettle   = 60;

   class run_contraction_board;
      typedef struct {
         arc_pkg::char_type ch;
         logic              is_last;
      } contracted_byte_type;

      contracted_byte_type contracted_q[$];
      arc_pkg::char_type   run_head;
      arc_pkg::char_type   run_tail;
      logic [1:0]          run_len_class;
      bit                  run_open;
      int                  mismatches;
      int                  bytes_checked;
      int                  runs_closed;
      int                  print_cap;

      function new();
         mismatches    = 0;
         bytes_checked = 0;
         runs_closed   = 0;
         print_cap     = 40;
         clear_run();
      endfunction

      function void clear_run();
         run_head      = '0;
         run_tail      = '0;
         run_len_class = arc_pkg::ClassOne;
         run_open      = 1'b0;
      endfunction

      function bit is_word_char(arc_pkg::char_type c);
         return (c >= arc_pkg::DigitLow && c < arc_pkg::DigitEnd) ||
                (c >= arc_pkg::UpperLow && c < arc_pkg::UpperEnd) ||
                (c >= arc_pkg::LowerLow && c < arc_pkg::LowerEnd);
      endfunction

      function void push_byte(arc_pkg::char_type c, logic is_last);
         contracted_byte_type e;
         e.ch      = c;
         e.is_last = is_last;
         contracted_q.push_back(e);
      endfunction

      function void close_run();
         runs_closed++;
         case (run_len_class)
            arc_pkg::ClassTwo: begin
               push_byte(run_head, 1'b0);
               push_byte(run_tail, 1'b1);
            end
            arc_pkg::ClassMore: begin
               push_byte(run_head, 1'b0);
               push_byte(arc_pkg::DashCode, 1'b0);
               push_byte(run_tail, 1'b1);
            end
            // a zero class would behave as a run of one
            default: push_byte(run_head, 1'b1);
         endcase
      endfunction

      // note one accepted input transfer and queue the bytes it releases
      function void predict_contraction(arc_pkg::char_type c, logic end_of_string);
         arc_pkg::char_type successor;
         successor = run_tail + 8'd1;
         if (end_of_string) begin
            if (run_open) close_run();
            clear_run();
         end else if (!run_open) begin
            run_open      = 1'b1;
            run_head      = c;
            run_tail      = c;
            run_len_class = arc_pkg::ClassOne;
         end else if (is_word_char(run_tail) && c == successor &&
                      run_tail != arc_pkg::MaxCode) begin
            if (run_len_class != arc_pkg::ClassMore) run_len_class = run_len_class + 2'd1;
            run_tail = c;
         end else begin
            close_run();
            run_head      = c;
            run_tail      = c;
            run_len_class = arc_pkg::ClassOne;
         end
      endfunction

      function int pending();
         return contracted_q.size();
      endfunction

      task report(string msg);
         if (mismatches < print_cap) $display("mismatch: %s", msg);
         mismatches++;
      endtask

      task check_contracted(arc_pkg::char_type got_ch, logic got_last);
         contracted_byte_type e;
         if (contracted_q.size() == 0) begin
            report($sformatf("unexpected byte 0x%02h last=%0b", got_ch, got_last));
         end else begin
            e = contracted_q.pop_front();
            bytes_checked++;
            if (got_ch !== e.ch)
               report($sformatf("byte %0d: out_char 0x%02h, want 0x%02h",
                                bytes_checked, got_ch, e.ch));
            if (got_last !== e.is_last)
               report($sformatf("byte %0d: last_of_run %0b, want %0b",
                                bytes_checked, got_last, e.is_last));
         end
      endtask
   endclass

   logic clock;
   logic reset;

   arc_req_if req_bus ();
   arc_rsp_if rsp_bus ();

   ascending_run_contractor i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   run_contraction_board board;

   bit choke;
   bit no_idle;
   int stall_left;
   int items_sent;
   int strings_sent;
   int drains_done;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #6_000_000;
      $display("simulation failed");
      $finish;
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_item(arc_pkg::char_type c, logic end_of_string);
      int gap;
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.in_char       <= c;
      req_bus.end_of_string <= end_of_string;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      board.predict_contraction(c, end_of_string);
      items_sent++;
   endtask

   task automatic send_end();
      send_item(arc_pkg::char_type'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic send_run(arc_pkg::char_type start, int len);
      arc_pkg::char_type c;
      c = start;
      repeat (len) begin
         send_item(c, 1'b0);
         c = c + 8'd1;
      end
   endtask

   // hold the input idle until all results are back
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
      drains_done++;
   endtask

   task automatic send_random_string();
      int segs;
      int kind;
      int len;
      arc_pkg::char_type start;
      arc_pkg::char_type edge_starts [9];
      edge_starts = '{"7", "8", "9", "X", "Y", "Z", "x", "y", "z"};
      segs = $urandom_range(1, 5);
      repeat (segs) begin
         kind = $urandom_range(0, 9);
         if (kind <= 5) begin
            case ($urandom_range(0, 2))
               0: start = arc_pkg::DigitLow + arc_pkg::char_type'($urandom_range(0, 9));
               1: start = arc_pkg::UpperLow + arc_pkg::char_type'($urandom_range(0, 25));
               default: start = arc_pkg::LowerLow + arc_pkg::char_type'($urandom_range(0, 25));
            endcase
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 14) : $urandom_range(1, 5);
            send_run(start, len);
         end else if (kind <= 7) begin
            send_item(arc_pkg::char_type'($urandom_range(0, 255)), 1'b0);
         end else if (kind == 8) begin
            // walk across the end of a character class
            send_run(edge_starts[$urandom_range(0, 8)], $urandom_range(2, 4));
         end else begin
            send_item(arc_pkg::MaxCode, 1'b0);
            if ($urandom_range(0, 1)) send_item(8'h00, 1'b0);
         end
      end
      len = $urandom_range(0, 9);
      if (len < 8) begin
         send_end();
      end else if (len == 9) begin
         send_end();
         send_end();
      end
      strings_sent++;
   endtask

   // result side: check each transfer, stall at random, hold ready low while choked
   initial begin
      rsp_bus.ready <= 1'b0;
      stall_left = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready)
            board.check_contracted(rsp_bus.out_char, rsp_bus.last_of_run);
         if (choke) begin
            rsp_bus.ready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
            choke = 1'b0;
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall_left = no_idle ? 0 : pick_gap();
         end
      end
   end

   initial begin
      int settle;
      board        = new();
      choke        = 1'b0;
      no_idle      = 1'b0;
      items_sent   = 0;
      strings_sent = 0;
      drains_done  = 0;
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.in_char       <= '0;
      req_bus.end_of_string <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // end with nothing open, then a zero byte as a run of one
      send_end();
      send_item(8'h00, 1'b0);
      send_end();
      send_run("a", 2);
      send_end();
      // the digit check lets a run step from nine onto a colon
      send_run("8", 4);
      send_end();
      send_item(arc_pkg::MaxCode, 1'b0);
      send_item(8'h00, 1'b0);
      send_end();
      send_run("y", 3);
      send_end();
      send_run("A", 5);
      send_end();
      wait_drained();

      while (items_sent < 24 + RandomItems) begin
         if (strings_sent == 3) choke = 1'b1;
         if (strings_sent % 15 == 7) wait_drained();
         no_idle = (strings_sent % 10) >= 7;
         send_random_string();
      end
      send_end();
      req_bus.valid <= 1'b0;
      no_idle = 1'b0;

      settle = 0;
      while (board.pending() != 0 && settle < DrainLimit) begin
         @(posedge clock);
         settle++;
      end
      if (board.pending() != 0)
         board.report($sformatf("%0d expected bytes never arrived", board.pending()));
      repeat (EndSettle) @(posedge clock);

      $display("covered %0d transfers in %0d strings, %0d runs closed, %0d bytes checked",
               items_sent, strings_sent, board.runs_closed, board.bytes_checked);
      $display("included a %0d-cycle result hold and %0d full drains", HoldCycles, drains_done);
      if (board.mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
